// ===== rtl/core/block_gradient_orientation_score_assert.svh =====
// Assertion helpers shared by the scorer RTL.
`ifndef BLOCK_GRADIENT_ORIENTATION_SCORE_ASSERT_SVH
`define BLOCK_GRADIENT_ORIENTATION_SCORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define GOS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds at every clock edge out of reset.
`define GOS_ASSERT_HOLDS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

`endif

// ===== rtl/core/gos_pkg.sv =====
package gos_pkg;

    localparam int BIN_W    = 3;
    localparam int NUM_BINS = 8;
    localparam int CNT_W    = 15;
    localparam int GRAD_W   = 13;
    localparam int THR_W    = 13;
    localparam int SQ_W     = 26;

    localparam int MAX_BLOCK_PIXELS = 16384;
    // Every bin and edge counter saturates here.
    localparam logic [CNT_W-1:0] COUNT_CAP =
        CNT_W'(MAX_BLOCK_PIXELS > 32767 ? 32767 : MAX_BLOCK_PIXELS);
    localparam logic [CNT_W-1:0] PEAK_MAX = {CNT_W{1'b1}};

    // tan 22.5 and tan 67.5 in Q16
    localparam logic [14:0] TAN_22_5_Q16 = 15'd27146;
    localparam logic [17:0] TAN_67_5_Q16 = 18'd158217;

    // strong block: 20 * peak >= 13 * count
    localparam logic [4:0] STRONG_PEAK_MUL  = 5'd20;
    localparam logic [4:0] STRONG_TOTAL_MUL = 5'd13;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_DATA_W = 15;

    // configuration register indexes
    localparam logic CFG_MAG_THR  = 1'b0;
    localparam logic CFG_MIN_EDGE = 1'b1;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [BIN_W-1:0] bin_t;

    // classified pixel leaving the front end
    typedef struct packed {
        logic valid;
        logic block_end;
        logic is_edge;
        logic has_bin;
        bin_t bin;
    } cls_t;

    // one bank access per cycle: a read and a write
    typedef struct packed {
        logic rd_en;
        bin_t rd_addr;
        logic wr_en;
        bin_t wr_addr;
        cnt_t wr_data;
    } bank_req_t;

    // hand-off of a finished block to the readout engine
    typedef struct packed {
        logic start;
        bin_t dom;
        cnt_t edge_total;
    } sweep_start_t;

endpackage

// ===== rtl/core/block_gradient_orientation_score.sv =====
// Block gradient orientation scorer: 8-bin angle histogram over one block of pixels.
// Input channel (s_): one word per pixel, tdata holds grad_x and grad_y, tlast marks the
// block's last pixel. Output channel (m_): one word per block with the dominant bin, the
// sum of that bin and its two circular neighbors, the edge count and the strong flag.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index (0 magnitude
// threshold, 1 minimum edge count); write only while the block is idle.
// Throughput: one pixel word per cycle. The bin counts live in two 8-entry banks; pixels
// accumulate in one bank by read-modify-write (registered read, forwarding on back-to-back
// hits) while the readout engine sweeps the other bank, collecting the peak sum and
// clearing each entry; the result word is loaded into the output register after the sweep.
// A tlast word waits (s_tready low for it alone) while the previous block's readout is
// still busy, so blocks shorter than 14 pixels run below one word per cycle.
// Receiver stall: the result holds in the output register; accumulation continues, and
// only the next tlast word waits until the readout engine has handed off its result.
// Reset: all counts read as zero (per-entry written bits), threshold 0, minimum 500.
`include "block_gradient_orientation_score_assert.svh"

module block_gradient_orientation_score (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: [12:0] grad_x, [25:13] grad_y, [31:26] zero
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gos_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tlast,
    // m_tdata: [2:0] dominant_bin, [17:3] peak_sum, [32:18] edge_count,
    //          [33] strong_block, [39:34] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gos_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [gos_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import gos_pkg::*;

    // configuration
    logic [SQ_W-1:0] thr_sq_reg;
    cnt_t            min_reg;

    // front end
    logic s_accept;
    cls_t cls;
    logic s1_block_end;
    logic be_in_flight;

    // accumulate stage (S3)
    logic s3_valid_reg;
    logic s3_be_reg;
    logic s3_edge_reg;
    logic s3_inc_reg;
    bin_t s3_bin_reg;
    logic s3_bank_reg;

    logic act_reg;
    cnt_t best_reg;
    bin_t dom_reg;
    cnt_t et_reg;

    logic fwd_valid_reg;
    logic fwd_bank_reg;
    bin_t fwd_bin_reg;
    cnt_t fwd_data_reg;

    logic pix_bank;
    logic pix_rd_en;
    logic pix_wr_en;
    logic fwd_hit;
    cnt_t pix_cur;
    logic pix_can_inc;
    cnt_t pix_new;
    cnt_t best_next;
    bin_t dom_next;
    cnt_t et_next;
    logic blk_close;

    // banks and readout
    bank_req_t    bank_req     [2];
    cnt_t         bank_rd_data [2];
    logic         bank_rd_wr   [2];
    logic         sw_bank;
    bank_req_t    sw_req;
    sweep_start_t sw_start;
    logic         sw_idle;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_sq_reg <= '0;
            min_reg    <= cnt_t'(500);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAG_THR: begin
                    thr_sq_reg <= SQ_W'(cfg_wr_data[THR_W-1:0]) *
                                  SQ_W'(cfg_wr_data[THR_W-1:0]);
                end
                CFG_MIN_EDGE: begin
                    min_reg <= cfg_wr_data;
                end
                default: begin
                    min_reg <= min_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------- input side
    // Hold back a tlast word while an earlier block end is in flight or in readout.
    assign be_in_flight = s1_block_end || (cls.valid && cls.block_end) ||
                          (s3_valid_reg && s3_be_reg);
    assign s_tready     = !s_tlast || (!be_in_flight && sw_idle);
    assign s_accept     = s_tvalid && s_tready;

    gos_classify u_classify (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_accept),
        .in_grad_x    (s_tdata[GRAD_W-1:0]),
        .in_grad_y    (s_tdata[2*GRAD_W-1:GRAD_W]),
        .in_block_end (s_tlast),
        .thr_sq       (thr_sq_reg),
        .s2           (cls),
        .s1_block_end (s1_block_end)
    );

    // ------------------------------------------------------- bank read (S2)
    // A block end leaving S3 flips the active bank this cycle, so the word
    // behind it already reads the fresh bank.
    assign blk_close = s3_valid_reg && s3_be_reg;
    assign pix_bank  = act_reg ^ blk_close;
    assign pix_rd_en = cls.valid && cls.is_edge && cls.has_bin;
    assign pix_wr_en = s3_valid_reg && s3_inc_reg;
    assign sw_bank   = ~act_reg;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            bank_req[k] = (sw_bank == 1'(k)) ? sw_req : '0;
            if (pix_rd_en && pix_bank == 1'(k)) begin
                bank_req[k].rd_en   = 1'b1;
                bank_req[k].rd_addr = cls.bin;
            end
            if (pix_wr_en && s3_bank_reg == 1'(k)) begin
                bank_req[k].wr_en   = 1'b1;
                bank_req[k].wr_addr = s3_bin_reg;
                bank_req[k].wr_data = pix_new;
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_bank
        gos_bank u_bank (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .req        (bank_req[g]),
            .rd_data    (bank_rd_data[g]),
            .rd_written (bank_rd_wr[g])
        );
    end

    // ------------------------------------------------- modify and write (S3)
    always_comb begin
        fwd_hit     = fwd_valid_reg && (fwd_bank_reg == s3_bank_reg) &&
                      (fwd_bin_reg == s3_bin_reg);
        // take the word written last cycle; the bank read missed it
        pix_cur     = fwd_hit ? fwd_data_reg :
                      (bank_rd_wr[s3_bank_reg] ? bank_rd_data[s3_bank_reg] : '0);
        pix_can_inc = pix_wr_en && (pix_cur < COUNT_CAP);
        pix_new     = pix_can_inc ? pix_cur + 15'd1 : pix_cur;

        // running first-largest bin: a tie moves it only to a lower index
        best_next = best_reg;
        dom_next  = dom_reg;
        if (pix_can_inc) begin
            if (pix_new > best_reg) begin
                best_next = pix_new;
                dom_next  = s3_bin_reg;
            end else if (pix_new == best_reg && s3_bin_reg < dom_reg) begin
                dom_next = s3_bin_reg;
            end
        end

        et_next = (s3_valid_reg && s3_edge_reg && et_reg < COUNT_CAP) ?
                  et_reg + 15'd1 : et_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            act_reg       <= 1'b0;
            best_reg      <= '0;
            dom_reg       <= '0;
            et_reg        <= '0;
        end else begin
            s3_valid_reg  <= cls.valid;
            fwd_valid_reg <= pix_wr_en;
            if (blk_close) begin
                // hand the finished bank to readout and start the next block
                act_reg  <= ~act_reg;
                best_reg <= '0;
                dom_reg  <= '0;
                et_reg   <= '0;
            end else begin
                best_reg <= best_next;
                dom_reg  <= dom_next;
                et_reg   <= et_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s3_be_reg    <= cls.block_end;
        s3_edge_reg  <= cls.is_edge;
        s3_inc_reg   <= cls.is_edge && cls.has_bin;
        s3_bin_reg   <= cls.bin;
        s3_bank_reg  <= pix_bank;
        fwd_bank_reg <= s3_bank_reg;
        fwd_bin_reg  <= s3_bin_reg;
        fwd_data_reg <= pix_new;
    end

    // ---------------------------------------------------------------- readout
    always_comb begin
        sw_start.start      = blk_close;
        sw_start.dom        = dom_next;
        sw_start.edge_total = et_next;
    end

    gos_sweep u_sweep (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (sw_start),
        .min_edge_count (min_reg),
        .rd_data        (bank_rd_data[sw_bank]),
        .rd_written     (bank_rd_wr[sw_bank]),
        .req            (sw_req),
        .idle           (sw_idle),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

    // ------------------------------------------------------------- assertions
    `GOS_ASSERT_IMP(a_close_needs_idle, aclk, aresetn, blk_close, sw_idle,
                    "block closed while readout busy")
    `GOS_ASSERT_IMP(a_bank_apart, aclk, aresetn, !sw_idle && pix_wr_en,
                    s3_bank_reg == act_reg, "pixel write hit the bank under readout")
    `GOS_ASSERT_HOLDS(a_peak_le_total, aclk, aresetn, best_reg <= et_reg,
                      "largest bin exceeds edge count")

endmodule

// ===== rtl/core/gos_bank.sv =====
module gos_bank (
    input  logic                aclk,
    input  logic                aresetn,
    input  gos_pkg::bank_req_t  req,
    output gos_pkg::cnt_t       rd_data,
    output logic                rd_written
);
    import gos_pkg::*;

    cnt_t                cnt_mem [NUM_BINS];
    logic [NUM_BINS-1:0] vld_reg;
    cnt_t                rd_data_reg;
    logic                rd_vld_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            cnt_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= cnt_mem[req.rd_addr];
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data    = rd_data_reg;
    assign rd_written = rd_vld_reg;

endmodule

// ===== rtl/core/gos_classify.sv =====
module gos_classify (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    input  logic signed [gos_pkg::GRAD_W-1:0]  in_grad_x,
    input  logic signed [gos_pkg::GRAD_W-1:0]  in_grad_y,
    input  logic                               in_block_end,
    input  logic [gos_pkg::SQ_W-1:0]           thr_sq,
    output gos_pkg::cls_t                      s2,
    output logic                               s1_block_end
);
    import gos_pkg::*;

    // stage A: raw fields
    logic                     a_valid_reg;
    logic                     a_be_reg;
    logic signed [GRAD_W-1:0] a_gx_reg;
    logic signed [GRAD_W-1:0] a_gy_reg;

    logic [GRAD_W-1:0] a_ax;
    logic [GRAD_W-1:0] a_ay;
    logic              a_gx_pos;
    logic [SQ_W-1:0]   a_sqx;
    logic [SQ_W-1:0]   a_sqy;
    logic [26:0]       a_p22;
    logic [29:0]       a_p67;

    // stage B: products
    logic              b_valid_reg;
    logic              b_be_reg;
    logic [SQ_W-1:0]   b_sqx_reg;
    logic [SQ_W-1:0]   b_sqy_reg;
    logic [GRAD_W-1:0] b_y_reg;
    logic [GRAD_W-1:0] b_ax_reg;
    logic              b_gx_pos_reg;
    logic              b_gx_zero_reg;
    logic [26:0]       b_p22_reg;
    logic [29:0]       b_p67_reg;

    logic [SQ_W-1:0] b_sum;
    logic [29:0]     b_ysh;
    logic [29:0]     b_y30;
    logic [29:0]     b_ax30;
    bin_t            b_bin;
    logic            b_has_bin;

    always_comb begin
        a_ax = a_gx_reg[GRAD_W-1] ? GRAD_W'(-a_gx_reg) : GRAD_W'(a_gx_reg);
        a_ay = a_gy_reg[GRAD_W-1] ? GRAD_W'(-a_gy_reg) : GRAD_W'(a_gy_reg);
        // fold the angle into [0, pi): a negative gy flips the sign of gx
        a_gx_pos = a_gy_reg[GRAD_W-1] ? a_gx_reg[GRAD_W-1]
                                      : (!a_gx_reg[GRAD_W-1] && (a_gx_reg != '0));
        a_sqx = SQ_W'(a_ax) * SQ_W'(a_ax);
        a_sqy = SQ_W'(a_ay) * SQ_W'(a_ay);
        a_p22 = 27'(a_ax) * 27'(TAN_22_5_Q16);
        a_p67 = 30'(a_ax) * 30'(TAN_67_5_Q16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_be_reg      <= in_block_end;
        a_gx_reg      <= in_grad_x;
        a_gy_reg      <= in_grad_y;
        b_be_reg      <= a_be_reg;
        b_sqx_reg     <= a_sqx;
        b_sqy_reg     <= a_sqy;
        b_y_reg       <= a_ay;
        b_ax_reg      <= a_ax;
        b_gx_pos_reg  <= a_gx_pos;
        b_gx_zero_reg <= (a_gx_reg == '0);
        b_p22_reg     <= a_p22;
        b_p67_reg     <= a_p67;
    end

    // angle bins; a value on a boundary lands in the higher bin
    always_comb begin
        b_sum     = b_sqx_reg + b_sqy_reg;
        b_ysh     = 30'({b_y_reg, 16'b0});
        b_y30     = 30'(b_y_reg);
        b_ax30    = 30'(b_ax_reg);
        b_bin     = 3'd0;
        b_has_bin = 1'b1;
        if (b_y_reg == '0) begin
            // along the x axis: angle zero, or angle pi which has no bin
            b_bin     = 3'd0;
            b_has_bin = b_gx_pos_reg;
        end else if (b_gx_pos_reg) begin
            if (b_ysh < 30'(b_p22_reg)) begin
                b_bin = 3'd0;
            end else if (b_y30 < b_ax30) begin
                b_bin = 3'd1;
            end else if (b_ysh < b_p67_reg) begin
                b_bin = 3'd2;
            end else begin
                b_bin = 3'd3;
            end
        end else if (b_gx_zero_reg) begin
            b_bin = 3'd4;
        end else begin
            if (b_ysh > b_p67_reg) begin
                b_bin = 3'd4;
            end else if (b_y30 > b_ax30) begin
                b_bin = 3'd5;
            end else if (b_ysh > 30'(b_p22_reg)) begin
                b_bin = 3'd6;
            end else begin
                b_bin = 3'd7;
            end
        end
    end

    always_comb begin
        s2.valid     = b_valid_reg;
        s2.block_end = b_be_reg;
        s2.is_edge   = (b_sum > thr_sq);
        s2.has_bin   = b_has_bin;
        s2.bin       = b_bin;
    end

    assign s1_block_end = a_valid_reg && a_be_reg;

endmodule

// ===== rtl/core/gos_sweep.sv =====
module gos_sweep (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gos_pkg::sweep_start_t             start,
    input  gos_pkg::cnt_t                     min_edge_count,
    input  gos_pkg::cnt_t                     rd_data,
    input  logic                              rd_written,
    output gos_pkg::bank_req_t                req,
    output logic                              idle,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gos_pkg::M_TDATA_W-1:0]     m_tdata
);
    import gos_pkg::*;

    localparam logic [1:0] SW_IDLE = 2'd0;
    localparam logic [1:0] SW_RUN  = 2'd1;
    localparam logic [1:0] SW_LAST = 2'd2;
    localparam logic [1:0] SW_DONE = 2'd3;

    logic [1:0]           state_reg;
    bin_t                 idx_reg;
    logic                 take_reg;
    bin_t                 take_idx_reg;
    bin_t                 dom_reg;
    cnt_t                 et_reg;
    logic [CNT_W+1:0]     acc_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    bin_t             dom_up;
    bin_t             dom_dn;
    logic             near;
    cnt_t             take_val;
    cnt_t             peak;
    logic             is_strong;
    logic             out_free;

    always_comb begin
        req         = '0;
        req.rd_en   = (state_reg == SW_RUN);
        req.wr_en   = (state_reg == SW_RUN);
        req.rd_addr = idx_reg;
        req.wr_addr = idx_reg;
        req.wr_data = '0;
    end

    always_comb begin
        dom_up    = dom_reg + 3'd1;
        dom_dn    = dom_reg - 3'd1;
        near      = (take_idx_reg == dom_reg) || (take_idx_reg == dom_up) ||
                    (take_idx_reg == dom_dn);
        take_val  = rd_written ? rd_data : '0;
        peak      = (acc_reg > (CNT_W+2)'(PEAK_MAX)) ? PEAK_MAX : acc_reg[CNT_W-1:0];
        is_strong = (et_reg > min_edge_count) &&
                    ((20'(peak) * 20'(STRONG_PEAK_MUL)) >=
                     (20'(et_reg) * 20'(STRONG_TOTAL_MUL)));
        out_free  = !m_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SW_IDLE;
            take_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // load a new word, or drop the old one once the receiver takes it
            if (state_reg == SW_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                SW_IDLE: begin
                    if (start.start) begin
                        state_reg <= SW_RUN;
                    end
                end
                SW_RUN: begin
                    take_reg <= 1'b1;
                    if (idx_reg == bin_t'(NUM_BINS - 1)) begin
                        state_reg <= SW_LAST;
                    end
                end
                SW_LAST: begin
                    take_reg  <= 1'b0;
                    state_reg <= SW_DONE;
                end
                SW_DONE: begin
                    if (out_free) begin
                        state_reg <= SW_IDLE;
                    end
                end
                default: begin
                    state_reg <= SW_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == SW_IDLE && start.start) begin
            idx_reg <= '0;
            dom_reg <= start.dom;
            et_reg  <= start.edge_total;
            acc_reg <= '0;
        end else begin
            if (state_reg == SW_RUN) begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (take_reg && near) begin
                acc_reg <= acc_reg + (CNT_W+2)'(take_val);
            end
        end
        take_idx_reg <= idx_reg;
        if (state_reg == SW_DONE && out_free) begin
            m_data_reg <= {6'b0, is_strong, et_reg, peak, dom_reg};
        end
    end

    assign idle     = (state_reg == SW_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Pixel words go in with grad_x/grad_y in tdata and the block end on tlast. A local
// histogram predictor builds the expected score for each block. Every result word is
// checked against the oldest pending score, field by field.
module tb;
    import gos_pkg::*;

    localparam int NO_BIN        = NUM_BINS;  // angle of exactly pi: an edge, but no bin
    localparam int GRAD_LIM      = 4080;
    localparam int THR_MAX       = 5771;
    localparam int MIN_EDGE_MAX  = 16384;
    localparam int PEAK_CAP      = 32767;
    localparam int SETTLE_CYCLES = 20;        // margin after a drain for the readout to empty
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_PIXELS   = 80;        // one long gapless block
    localparam int PHASE_PIXELS  = 80;

    // Same layout as m_tdata, lowest field last in the declaration.
    typedef struct packed {
        logic strong_flag;
        cnt_t edges;
        cnt_t peak;
        bin_t dom;
    } block_score_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic                   s_tlast     = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en   = 1'b0;
    logic                   cfg_index   = CFG_MAG_THR;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    // Predictor state: histogram, edge count and the two settings.
    int unsigned  bin_tally [NUM_BINS];
    int unsigned  edge_tally;
    int unsigned  thr_setting      = 0;
    int unsigned  min_edge_setting = 500;
    block_score_t pending_scores [$];

    block_score_t score_want, score_got;
    int  errors, pixels_sent, blocks_sent, scores_checked, strong_blocks, pi_pixels;
    bit  steady;  // set: no gaps on either side

    block_gradient_orientation_score dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop: a hang or a lost result word ends up here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("%0t ns: timeout with %0d scores pending", $time, pending_scores.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // Fold the angle into [0, pi) and pick the 22.5 degree sector. Boundaries go up.
    function automatic int orientation_bin(longint gx, longint gy);
        longint ax, t_lo, t_hi;
        t_lo = TAN_22_5_Q16;
        t_hi = TAN_67_5_Q16;
        if (gy < 0) begin
            gx = -gx;
            gy = -gy;
        end
        if (gy == 0) return (gx > 0) ? 0 : NO_BIN;
        if (gx > 0) begin
            if (gy * 65536 < gx * t_lo) return 0;
            if (gy < gx) return 1;
            if (gy * 65536 < gx * t_hi) return 2;
            return 3;
        end
        if (gx == 0) return 4;
        ax = -gx;
        if (gy * 65536 > ax * t_hi) return 4;
        if (gy > ax) return 5;
        if (gy * 65536 > ax * t_lo) return 6;
        return 7;
    endfunction

    // Count one accepted pixel; on the block end, queue the score and clear.
    function automatic void tally_pixel(logic signed [GRAD_W-1:0] gx,
                                        logic signed [GRAD_W-1:0] gy, logic last);
        longint       sx, sy, thr;
        int           b, d;
        int unsigned  best, peak;
        block_score_t score;
        sx = gx;
        sy = gy;
        thr = thr_setting;
        if (sx * sx + sy * sy > thr * thr) begin
            b = orientation_bin(sx, sy);
            if (edge_tally < COUNT_CAP) edge_tally++;
            if (b == NO_BIN) pi_pixels++;
            else if (bin_tally[b] < COUNT_CAP) bin_tally[b]++;
        end
        if (!last) return;
        best = 0;
        d = 0;
        for (int i = 0; i < NUM_BINS; i++) begin
            if (bin_tally[i] > best) begin
                best = bin_tally[i];
                d = i;
            end
        end
        peak = bin_tally[(d + NUM_BINS - 1) % NUM_BINS] + bin_tally[d]
             + bin_tally[(d + 1) % NUM_BINS];
        if (peak > PEAK_CAP) peak = PEAK_CAP;
        score.dom         = bin_t'(d);
        score.peak        = cnt_t'(peak);
        score.edges       = cnt_t'(edge_tally);
        score.strong_flag = (edge_tally > min_edge_setting) &&
                            (longint'(peak) * STRONG_PEAK_MUL >=
                             longint'(edge_tally) * STRONG_TOTAL_MUL);
        if (score.strong_flag) strong_blocks++;
        pending_scores.insert(pending_scores.size(), score);
        blocks_sent++;
        for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = 0;
        edge_tally = 0;
    endfunction

    // ---------------------------------------------------------------- result check

    function automatic void compare_field(string name, int expd, int actual);
        if (expd != actual) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, name, expd, actual);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_scores.size() == 0) begin
                errors++;
                $display("%0t ns: result word with none expected, expected nothing, got %h",
                         $time, m_tdata);
            end else begin
                score_want = pending_scores.pop_front();
                score_got  = m_tdata[$bits(block_score_t)-1:0];
                compare_field("dominant_bin", score_want.dom,   score_got.dom);
                compare_field("peak_sum",     score_want.peak,  score_got.peak);
                compare_field("edge_count",   score_want.edges, score_got.edges);
                compare_field("strong_block", score_want.strong_flag,
                              score_got.strong_flag);
                scores_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- idling

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic int receiver_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Toggle m_tready in runs; hold it high while steady.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (steady) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                stall = receiver_stall();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int clamp_grad(int v);
        if (v > GRAD_LIM) return GRAD_LIM;
        if (v < -GRAD_LIM) return -GRAD_LIM;
        return v;
    endfunction

    // Offer one pixel word, hold it until accepted, then predict on it.
    task automatic send_pixel(input int gx, input int gy, input logic last);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({gy[GRAD_W-1:0], gx[GRAD_W-1:0]});
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tally_pixel(gx[GRAD_W-1:0], gy[GRAD_W-1:0], last);
        pixels_sent++;
    endtask

    // Drop valid and hold off until every pending score has come back.
    task automatic await_scores();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_scores.size() != 0);
    endtask

    // Write one setting while idle; let the readout pipeline empty first.
    task automatic write_setting(input logic idx, input int unsigned value);
        await_scores();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == CFG_MAG_THR) thr_setting = value;
        else min_edge_setting = value;
    endtask

    // ---------------------------------------------------------------- tests

    // Reset settings (threshold 0, minimum 500): axes, diagonals, the pi angle,
    // sector edges near tan 22.5 / 67.5, a flat pixel, the empty histogram,
    // a tie between bins and the wrap of the neighbor sum.
    task automatic test_directed_angles();
        steady = 1'b0;
        send_pixel( 4080,     0, 1'b0);
        send_pixel(-4080,     0, 1'b0);  // pi: edge without a bin
        send_pixel(    0,  4080, 1'b0);
        send_pixel(    0, -4080, 1'b0);
        send_pixel( 4080,  4080, 1'b0);  // 45 degrees lands in the upper sector
        send_pixel(-4080,  4080, 1'b0);  // 135 degrees, same rule
        send_pixel( 4080, -4080, 1'b0);
        send_pixel( 4080,  1690, 1'b0);  // just above tan 22.5
        send_pixel( 4080,  1689, 1'b0);  // just below
        send_pixel( 1690,  4080, 1'b0);  // around tan 67.5
        send_pixel( 1691,  4080, 1'b0);
        send_pixel(   -1,     1, 1'b0);
        send_pixel(    1, -4080, 1'b0);
        send_pixel(    0,     0, 1'b0);  // zero magnitude: never an edge
        send_pixel(-4080,    -1, 1'b0);
        send_pixel(-2000,   700, 1'b1);  // block end pixel counts toward its own score

        send_pixel(    0,     0, 1'b1);  // empty histogram
        send_pixel(-4080,     0, 1'b1);  // one edge, still no bin

        // Three-way tie across 5, 7 and 0: the lowest bin wins, neighbor sum wraps to bin 7.
        send_pixel(-2000,  3000, 1'b0);
        send_pixel(-2000,  3000, 1'b0);
        send_pixel(-4000,   100, 1'b0);
        send_pixel(-4000,   100, 1'b0);
        send_pixel( 4000,   100, 1'b0);
        send_pixel( 4000,   100, 1'b1);
        await_scores();
    endtask

    // One long block with no gaps on either side, split between bins 0 and 1
    // with a pi pixel mixed in; the minimum is still the reset value.
    task automatic test_long_block();
        int y, sgn;
        steady = 1'b1;
        for (int i = 0; i < LONG_PIXELS; i++) begin
            sgn = $urandom_range(0, 1) ? 1 : -1;
            y = (i % 2 == 0) ? $urandom_range(0, 1600) : $urandom_range(1700, 3900);
            if (i % 100 == 50) send_pixel(-$urandom_range(1, GRAD_LIM), 0, 1'b0);
            else send_pixel(sgn * 4000, sgn * y, i == LONG_PIXELS - 1);
        end
        await_scores();
        steady = 1'b0;
    endtask

    // Blocks of random length under one setting: mostly clustered around a
    // direction so strong blocks show up, the rest scattered, flat or at pi.
    task automatic test_random_blocks(input int unsigned thr, input int unsigned min_edges);
        int left, len, base_x, base_y, r, gx, gy;
        write_setting(CFG_MAG_THR, thr);
        write_setting(CFG_MIN_EDGE, min_edges);
        left = PHASE_PIXELS;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            if (len > left) len = left;
            left -= len;
            base_x = $urandom_range(0, 2 * GRAD_LIM) - GRAD_LIM;
            base_y = $urandom_range(0, 2 * GRAD_LIM) - GRAD_LIM;
            steady = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    gx = clamp_grad(base_x + $urandom_range(0, 400) - 200);
                    gy = clamp_grad(base_y + $urandom_range(0, 400) - 200);
                end else if (r < 88) begin
                    gx = $urandom_range(0, 2 * GRAD_LIM) - GRAD_LIM;
                    gy = $urandom_range(0, 2 * GRAD_LIM) - GRAD_LIM;
                end else if (r < 94) begin
                    gx = 0;
                    gy = 0;
                end else begin
                    gx = -$urandom_range(1, GRAD_LIM);
                    gy = 0;
                end
                send_pixel(gx, gy, i == len - 1);
            end
            // Now and then hold the sender until the pipeline has emptied.
            if ($urandom_range(0, 7) == 0) await_scores();
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = 0;
        edge_tally = 0;
        errors = 0;
        pixels_sent = 0;
        blocks_sent = 0;
        scores_checked = 0;
        strong_blocks = 0;
        pi_pixels = 0;
        steady = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_angles();
        test_long_block();
        test_random_blocks(0, 0);
        test_random_blocks(THR_MAX, MIN_EDGE_MAX);
        test_random_blocks(1, 1);
        test_random_blocks($urandom_range(500, 3000), $urandom_range(0, 30));
        test_random_blocks($urandom_range(0, THR_MAX), 500);

        // Drain, then give the readout time to show any stray word.
        await_scores();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_scores.size() != 0) begin
            errors++;
            $display("%0t ns: scores left over, expected 0, got %0d",
                     $time, pending_scores.size());
        end

        $display("Ran %0d pixels in %0d blocks; %0d scores checked, %0d strong, %0d at pi.",
                 pixels_sent, blocks_sent, scores_checked, strong_blocks, pi_pixels);
        $display("Thresholds 0..%0d and minimum edge counts 0..%0d, plus one gapless block.",
                 THR_MAX, MIN_EDGE_MAX);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
